// ===== rtl/core/csplit_pkg.sv =====
package csplit_pkg;

    // Widths of the distance and exponent formats.
    localparam int DistW = 24;
    localparam int ExpW  = 12;

    // Exponent clamp limits in Q4.8, about 0.1 and 10.0.
    localparam logic [ExpW-1:0] ExpMin = 12'd26;
    localparam logic [ExpW-1:0] ExpMax = 12'd2560;

    // Register reset values.
    localparam logic [ExpW-1:0]  ExpReset    = 12'd768;
    localparam logic [DistW-1:0] MaxDistReset = 24'd76800;

    // Register indexes on the configuration port.
    localparam int AddrW = 5;
    localparam logic [AddrW-1:0] RegExp     = 5'd0;
    localparam logic [AddrW-1:0] RegMaxDist = 5'd4;
    localparam logic [AddrW-1:0] RegSplit1  = 5'd8;
    localparam logic [AddrW-1:0] RegSplit2  = 5'd12;
    localparam logic [AddrW-1:0] RegSplit3  = 5'd16;
    localparam logic [AddrW-1:0] RegGeo     = 5'd20;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [ExpW-1:0]  exponent;
        logic [DistW-1:0] max_dist;
        logic [DistW-1:0] split_1;
        logic [DistW-1:0] split_2;
        logic [DistW-1:0] split_3;
        logic             geometric;
    } cfg_t;

endpackage

// ===== rtl/core/csplit_cfg.sv =====
module csplit_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csplit_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output csplit_pkg::cfg_t           cfg
);
    import csplit_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exponent  <= ExpReset;
            cfg_reg.max_dist  <= MaxDistReset;
            cfg_reg.split_1   <= '0;
            cfg_reg.split_2   <= '0;
            cfg_reg.split_3   <= '0;
            cfg_reg.geometric <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr)
                RegExp:     cfg_reg.exponent  <= pwdata[ExpW-1:0];
                RegMaxDist: cfg_reg.max_dist  <= pwdata[DistW-1:0];
                RegSplit1:  cfg_reg.split_1   <= pwdata[DistW-1:0];
                RegSplit2:  cfg_reg.split_2   <= pwdata[DistW-1:0];
                RegSplit3:  cfg_reg.split_3   <= pwdata[DistW-1:0];
                RegGeo:     cfg_reg.geometric <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (paddr)
            RegExp:     prdata = 32'(cfg_reg.exponent);
            RegMaxDist: prdata = 32'(cfg_reg.max_dist);
            RegSplit1:  prdata = 32'(cfg_reg.split_1);
            RegSplit2:  prdata = 32'(cfg_reg.split_2);
            RegSplit3:  prdata = 32'(cfg_reg.split_3);
            RegGeo:     prdata = 32'(cfg_reg.geometric);
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/cascade_shadow_split_calc.sv =====
// Cascade shadow split calculator.
// Each input item carries a view's near and far distance (Q16.8 metres); each
// output item carries the five cascade boundaries for that view. Boundary 0 is
// the near distance, boundary 4 is min(far, max distance), and the inner three
// come from the authored registers or from a geometric series in the exponent;
// the five are then made non-decreasing. The registers sit on an APB port; the
// user must have them written only while no item is in flight, which the block
// does not enforce. One item is accepted per cycle unless stalled; the pipeline
// has 22 stages, 16 of which form a restoring divider that yields one fraction
// bit per stage. Each stage holds its item until the stage after it is free, so
// when the receiver stalls the pipeline fills up and keeps every item; inputs
// are still taken while empty stages remain. Reset clears the pipeline and loads
// the register defaults (exponent 3.0, max distance 300 m, authored mode).
module cascade_shadow_split_calc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csplit_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,  // near_distance, far_distance
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [119:0]                 m_tdata   // split_0 .. split_4
);
    import csplit_pkg::*;

    localparam int NDiv   = 16;
    localparam int SDiv   = 3;
    localparam int SMul   = SDiv + NDiv;
    localparam int SSrc   = SMul + 1;
    localparam int SOut   = SSrc + 1;
    localparam int NStage = SOut + 1;
    localparam int RemW   = 35;
    localparam logic [RemW-1:0] WeightOne = 35'h1000000;

    typedef struct packed {
        logic [DistW-1:0]          near;
        logic [DistW-1:0]          cap;
        logic [DistW-1:0]          span;
        logic [ExpW-1:0]           e;
        logic [23:0]               e2;
        logic [33:0]               e3;
        logic [RemW-1:0]           tot;
        logic [2:0][RemW-1:0]      rem;
        logic [2:0][NDiv-1:0]      q;
        logic [2:0][39:0]          prod;
        logic [4:0][DistW-1:0]     s;
    } pipe_t;

    cfg_t  cfg;
    pipe_t stage_reg  [NStage];
    pipe_t stage_next [NStage];
    logic [NStage-1:0] valid_reg;
    logic [NStage:0]   ready;

    logic [DistW-1:0] in_near;
    logic [DistW-1:0] in_far;
    logic [ExpW-1:0]  e_clamp;

    csplit_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_near = s_tdata[23:0];
    assign in_far  = s_tdata[47:24];

    // Clamp the exponent into its legal range.
    always_comb
    begin
        if (cfg.exponent < ExpMin)
            e_clamp = ExpMin;
        else if (cfg.exponent > ExpMax)
            e_clamp = ExpMax;
        else
            e_clamp = cfg.exponent;
    end

    // Per-stage work.
    always_comb
    begin
        logic [RemW:0] dbl;
        logic [DistW-1:0] src;

        // Entry: cap, span and e squared.
        stage_next[0]      = '0;
        stage_next[0].near = in_near;
        stage_next[0].cap  = (in_far < cfg.max_dist) ? in_far : cfg.max_dist;
        stage_next[0].span = (cfg.max_dist > in_near) ? (cfg.max_dist - in_near) : '0;
        stage_next[0].e    = e_clamp;
        stage_next[0].e2   = 24'(e_clamp) * 24'(e_clamp);

        // Cube and the partial sums of the weights.
        stage_next[1]        = stage_reg[0];
        stage_next[1].e3     = 34'(stage_reg[0].e2) * 34'(stage_reg[0].e);
        stage_next[1].rem[0] = WeightOne;
        stage_next[1].rem[1] = WeightOne + (RemW'(stage_reg[0].e) << 16);
        stage_next[1].rem[2] = stage_next[1].rem[1] + (RemW'(stage_reg[0].e2) << 8);

        // Total of all four weights.
        stage_next[2]     = stage_reg[1];
        stage_next[2].tot = stage_reg[1].rem[2] + RemW'(stage_reg[1].e3);

        // Restoring division, one quotient bit per stage.
        for (int k = SDiv; k < SMul; k++)
        begin
            stage_next[k] = stage_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                dbl = {stage_reg[k-1].rem[i], 1'b0};
                if (dbl >= {1'b0, stage_reg[k-1].tot})
                begin
                    stage_next[k].rem[i] = RemW'(dbl - {1'b0, stage_reg[k-1].tot});
                    stage_next[k].q[i]   = {stage_reg[k-1].q[i][NDiv-2:0], 1'b1};
                end
                else
                begin
                    stage_next[k].rem[i] = dbl[RemW-1:0];
                    stage_next[k].q[i]   = {stage_reg[k-1].q[i][NDiv-2:0], 1'b0};
                end
            end
        end

        // Scale the fractions by the span.
        stage_next[SMul] = stage_reg[SMul-1];
        for (int i = 0; i < 3; i++)
            stage_next[SMul].prod[i] = 40'(stage_reg[SMul-1].q[i])
                                     * 40'(stage_reg[SMul-1].span);

        // Pick the source and limit it to the cap.
        stage_next[SSrc]      = stage_reg[SSrc-1];
        stage_next[SSrc].s[0] = stage_reg[SSrc-1].near;
        stage_next[SSrc].s[4] = stage_reg[SSrc-1].cap;
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.geometric)
                src = stage_reg[SSrc-1].near + stage_reg[SSrc-1].prod[i][39:16];
            else if (i == 0)
                src = cfg.split_1;
            else if (i == 1)
                src = cfg.split_2;
            else
                src = cfg.split_3;
            stage_next[SSrc].s[i+1] = (src < stage_reg[SSrc-1].cap) ? src
                                                                    : stage_reg[SSrc-1].cap;
        end

        // Raise each boundary to at least the one before it.
        stage_next[SOut] = stage_reg[SOut-1];
        for (int i = 1; i < 5; i++)
        begin
            if (stage_next[SOut].s[i] < stage_next[SOut].s[i-1])
                stage_next[SOut].s[i] = stage_next[SOut].s[i-1];
        end
    end

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        ready[NStage] = m_tready;
        for (int k = NStage - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign s_tready = ready[0];

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NStage; k++)
            begin
                if (ready[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NStage; k++)
        begin
            if (ready[k])
                stage_reg[k] <= stage_next[k];
        end
    end

    assign m_tvalid = valid_reg[NStage-1];
    assign m_tdata  = {stage_reg[NStage-1].s[4], stage_reg[NStage-1].s[3],
                       stage_reg[NStage-1].s[2], stage_reg[NStage-1].s[1],
                       stage_reg[NStage-1].s[0]};

endmodule
